// ===== rtl/lcg48br_pkg.sv =====
// ============================================================================
// lcg48br_pkg
// Shared widths, constants and control structs of the bounded random core.
// ============================================================================
`default_nettype none

package lcg48br_pkg;

    localparam int SEED_W  = 48;
    localparam int WORD_W  = 32;
    localparam int BOUND_W = 31;
    localparam int MULT_W  = 35;
    localparam int CHUNK_W = 16;
    localparam int DIVD_W  = 33;
    localparam int DCNT_W  = 6;

    localparam logic [MULT_W-1:0]  LCG_MULT    = 35'h5_DEEC_E66D;
    localparam logic [SEED_W-1:0]  LCG_MULT48  = 48'h0005_DEEC_E66D;
    localparam logic [SEED_W-1:0]  LCG_INC     = 48'h0000_0000_000B;
    localparam logic [BOUND_W-1:0] BOUND_RESET = 31'd4096;
    localparam logic [DIVD_W-1:0]  TWO_POW_32  = 33'h1_0000_0000;
    localparam logic [WORD_W-1:0]  SIGN_WORD   = 32'h8000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [SEED_W-1:0] seed;
    } lcg_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SEED_W-1:0] state;
    } lcg_stat_t;

    typedef struct packed {
        logic               start;
        logic [DIVD_W-1:0]  dividend;
        logic [BOUND_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [BOUND_W-1:0] rem;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lcg48br_lcg.sv =====
// ============================================================================
// lcg48br_lcg
// 48-bit congruential generator state with a 16x35 multiply-accumulate that
// forms one step in three passes.
// ============================================================================
`default_nettype none

module lcg48br_lcg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lcg48br_pkg::lcg_ctrl_t ctrl,
    output lcg48br_pkg::lcg_stat_t      stat
);
    import lcg48br_pkg::*;

    logic [SEED_W-1:0]         state_reg;
    logic [SEED_W-1:0]         acc_reg;
    logic [SEED_W-1:0]         acc_next;
    logic [1:0]                idx_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [CHUNK_W-1:0]        chunk;
    logic [CHUNK_W+MULT_W-1:0] prod;
    logic [SEED_W-1:0]         term;

    always_comb begin
        unique case (idx_reg)
            2'd0:    chunk = state_reg[15:0];
            2'd1:    chunk = state_reg[31:16];
            2'd2:    chunk = state_reg[47:32];
            default: chunk = '0;
        endcase
        prod = {{MULT_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, LCG_MULT};
        unique case (idx_reg)
            2'd0:    term = prod[47:0];
            2'd1:    term = {prod[31:0], 16'b0};
            2'd2:    term = {prod[15:0], 32'b0};
            default: term = '0;
        endcase
        acc_next = acc_reg + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LCG_MULT48;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.load) begin
                state_reg <= ctrl.seed ^ LCG_MULT48;
            end else if (ctrl.step && !busy_reg) begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end else if (busy_reg) begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd2) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    state_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step && !busy_reg) begin
            acc_reg <= LCG_INC;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/lcg48br_rem.sv =====
// ============================================================================
// lcg48br_rem
// Restoring remainder unit, one dividend bit per cycle.
// ============================================================================
`default_nettype none

module lcg48br_rem (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lcg48br_pkg::div_ctrl_t ctrl,
    output lcg48br_pkg::div_stat_t      stat
);
    import lcg48br_pkg::*;

    logic [DIVD_W-1:0]  dvd_reg;
    logic [BOUND_W-1:0] dsr_reg;
    logic [BOUND_W-1:0] rem_reg;
    logic [BOUND_W-1:0] rem_next;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [BOUND_W:0]   shifted;
    logic [BOUND_W:0]   diff;

    always_comb begin
        shifted = {rem_reg, dvd_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        if (shifted >= {1'b0, dsr_reg}) begin
            rem_next = diff[BOUND_W-1:0];
        end else begin
            rem_next = shifted[BOUND_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start && !busy_reg) begin
            dvd_reg <= ctrl.dividend;
            dsr_reg <= ctrl.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/lcg48_bounded_random_core.sv =====
// ============================================================================
// lcg48_bounded_random_core
// Bounded random draws from a 48-bit linear congruential generator.
// ============================================================================
// A load word (tuser 0) replaces the generator state with the seed XOR
// 0x5DEECE66D and returns nothing. A draw word (tuser 1) returns one value
// below the bound register. Each generator step runs through the three-pass
// 16x35 multiply-accumulate. A power-of-two bound costs one step per draw.
// Any other bound adds a pass through the serial one-bit-per-cycle remainder
// unit for the final value. Each rejected word costs one more step. The first
// draw after a bound write also runs the remainder unit to find 2^32 mod
// bound. Only one word is in flight, and the input is not ready until the
// result is registered.
`default_nettype none

module lcg48_bounded_random_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                bound_we,
    input  wire logic [lcg48br_pkg::BOUND_W-1:0]     bound_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lcg48br_pkg::SEED_W-1:0]      s_tdata,   // seed_value
    input  wire logic                                s_tuser,   // cmd
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [lcg48br_pkg::WORD_W-1:0]           m_tdata    // value, zero pad
);
    import lcg48br_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_STEP,
        ST_REM,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic [BOUND_W-1:0] mod_reg;
    logic               mod_ok_reg;
    logic               neg_reg;
    logic               m_tvalid_reg;
    logic [BOUND_W-1:0] value_reg;
    logic [BOUND_W-1:0] result_reg;
    logic               lcg_load_reg;
    logic               lcg_step_reg;
    logic [SEED_W-1:0]  seed_reg;
    logic               div_start_reg;
    logic [DIVD_W-1:0]  dividend_reg;

    lcg_ctrl_t          lcg_ctrl;
    lcg_stat_t          lcg_st;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_st;

    logic               is_pow2;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  limit;
    logic               reject;
    logic [BOUND_W-1:0] pow2_val;
    logic               in_fire;

    assign in_fire = s_tvalid && s_tready;
    assign is_pow2 = (bound_reg & (bound_reg - 1'b1)) == '0;
    assign word    = lcg_st.state[SEED_W-1:SEED_W-WORD_W];
    assign limit   = SIGN_WORD - {1'b0, mod_reg};
    assign reject  = !word[WORD_W-1] && (word >= limit);

    always_comb begin
        pow2_val = '0;
        for (int k = 0; k < BOUND_W; k++) begin
            pow2_val = pow2_val | (BOUND_W'(word >> (WORD_W - k)) & {BOUND_W{bound_reg[k]}});
        end
    end

    assign lcg_ctrl.load     = lcg_load_reg;
    assign lcg_ctrl.step     = lcg_step_reg;
    assign lcg_ctrl.seed     = seed_reg;
    assign div_ctrl.start    = div_start_reg;
    assign div_ctrl.dividend = dividend_reg;
    assign div_ctrl.divisor  = bound_reg;

    lcg48br_lcg u_lcg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lcg_ctrl),
        .stat    (lcg_st)
    );

    lcg48br_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bound_reg     <= BOUND_RESET;
            mod_ok_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            lcg_load_reg  <= 1'b0;
            lcg_step_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            lcg_load_reg  <= 1'b0;
            lcg_step_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            if (bound_we) begin
                bound_reg  <= bound_wdata;
                mod_ok_reg <= 1'b0;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_tuser == CMD_LOAD) begin
                            lcg_load_reg <= 1'b1;
                            seed_reg     <= s_tdata;
                        end else if (is_pow2 || mod_ok_reg) begin
                            lcg_step_reg <= 1'b1;
                            state_reg    <= ST_STEP;
                        end else begin
                            div_start_reg <= 1'b1;
                            dividend_reg  <= TWO_POW_32;
                            state_reg     <= ST_MOD;
                        end
                    end
                end
                ST_MOD: begin
                    if (div_st.done) begin
                        mod_reg      <= div_st.rem;
                        mod_ok_reg   <= 1'b1;
                        lcg_step_reg <= 1'b1;
                        state_reg    <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (lcg_st.done) begin
                        if (is_pow2) begin
                            result_reg <= pow2_val;
                            state_reg  <= ST_DONE;
                        end else if (reject) begin
                            lcg_step_reg <= 1'b1;
                        end else begin
                            neg_reg       <= word[WORD_W-1];
                            div_start_reg <= 1'b1;
                            dividend_reg  <= word[WORD_W-1]
                                ? {2'b00, ~word[BOUND_W-1:0]}
                                : {2'b00, word[BOUND_W-1:0]};
                            state_reg     <= ST_REM;
                        end
                    end
                end
                ST_REM: begin
                    if (div_st.done) begin
                        result_reg <= neg_reg ? (bound_reg - 1'b1 - div_st.rem) : div_st.rem;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        value_reg    <= result_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, value_reg};

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!lcg_st.busy && !div_st.busy))
        else $error("generator or remainder unit busy while idle");

    a_rem_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |-> !lcg_st.busy)
        else $error("generator stepping during remainder");

    a_step_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> !div_st.busy)
        else $error("remainder unit busy during generator step");

endmodule

`default_nettype wire
